// File: sv/apxsim_pkg.sv
// ----------------------------------------------------------------------------
// Approximate substring similarity package
// Operation codes, result constants and the structs shared by the cells,
// the divider and the top level.
// ----------------------------------------------------------------------------
package apxsim_pkg;

   // Operation codes carried by req_op.
   localparam logic [1:0] OP_KEY   = 2'd0;
   localparam logic [1:0] OP_WORD  = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // Result constants.
   localparam logic [7:0] SIM_ONE_EDIT = 8'd90;
   localparam logic [7:0] SIM_EMPTY    = 8'hFF;
   localparam int         PCT_SCALE    = 100;
   localparam logic [6:0] DIST_MAX     = 7'd127;

   // Broadcast control seen by one cell of the row.
   typedef struct packed {
      logic       clear;
      logic       key_we;
      logic [7:0] key_ch;
   } cell_ctrl_type;

   // Divider status.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: sv/apxsim_cell.sv
// ----------------------------------------------------------------------------
// Approximate substring similarity: one cell of the row
// Holds one key byte and one entry of the edit-distance column, and passes
// each word byte on to its neighbour in the following cycle.
// ----------------------------------------------------------------------------
module apxsim_cell
   import apxsim_pkg::*;
#(
   parameter int DW  = 7,
   parameter int POS = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          in_valid,
   input  logic [7:0]    in_ch,
   input  logic [DW-1:0] in_diag,
   input  logic [DW-1:0] in_left,
   output logic          out_valid,
   output logic [7:0]    out_ch,
   output logic [DW-1:0] out_old,
   output logic [DW-1:0] out_new
);

   localparam logic [DW-1:0] POS_V = DW'(POS);

   logic [7:0]    key_ff;
   logic [DW-1:0] dp_ff;
   logic [DW-1:0] dp_in;
   logic          valid_ff;
   logic [7:0]    ch_ff;
   logic [DW-1:0] old_ff;
   logic [DW-1:0] new_ff;

   logic [DW-1:0] up;
   logic [DW-1:0] by_del;
   logic [DW-1:0] by_sub;
   logic [DW-1:0] by_ins;
   logic [DW-1:0] best;

   // A new word starts from the position itself.
   assign up     = ctrl.clear ? POS_V : dp_ff;
   assign by_del = up + DW'(1);
   assign by_sub = in_diag + DW'(key_ff != in_ch);
   assign by_ins = in_left + DW'(1);

   always_comb begin
      best = by_del;
      if (by_sub < best) begin
         best = by_sub;
      end
      if (by_ins < best) begin
         best = by_ins;
      end
   end

   always_comb begin
      dp_in = dp_ff;
      if (in_valid) begin
         dp_in = best;
      end else if (ctrl.clear) begin
         dp_in = POS_V;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.key_we) begin
         key_ff <= ctrl.key_ch;
      end
      dp_ff  <= dp_in;
      ch_ff  <= in_ch;
      old_ff <= up;
      new_ff <= best;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_ch    = ch_ff;
   assign out_old   = old_ff;
   assign out_new   = new_ff;

endmodule

// File: sv/apxsim_div.sv
// ----------------------------------------------------------------------------
// Approximate substring similarity: score divider
// Restoring divider that yields one quotient bit per cycle. The quotient is
// given as it will stand after the current step, so it is complete in the
// cycle in which done is high.
// ----------------------------------------------------------------------------
module apxsim_div
   import apxsim_pkg::*;
#(
   parameter int NW = 13,
   parameter int LW = 7
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [NW-1:0]  num,
   input  logic [LW-1:0]  den,
   output div_status_type status,
   output logic [NW-1:0]  quo
);

   localparam int CW = $clog2(NW + 1);

   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic [LW-1:0] rem_ff;
   logic [LW-1:0] rem_in;
   logic [NW-1:0] quo_ff;
   logic [NW-1:0] quo_in;
   logic [LW-1:0] den_ff;

   logic [LW:0] trial;
   logic [LW:0] diff;
   logic        fits;

   assign trial = {rem_ff, quo_ff[NW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (start) begin
         cnt_in = CW'(NW);
         rem_in = '0;
         quo_in = num;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CW'(1);
         rem_in = fits ? diff[LW-1:0] : trial[LW-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= den;
      end
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign status.busy = (cnt_ff != '0);
   assign status.done = (cnt_ff == CW'(1));
   assign quo         = quo_in;

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (cnt_ff == '0))
      else $error("divider started while busy");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (den_ff != '0))
      else $error("divider running on a zero divisor");

   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      status.done |=> !status.busy)
      else $error("divider kept running after its last step");
`endif

endmodule

// File: sv/approx_substring_similarity.sv
// ----------------------------------------------------------------------------
// Approximate substring similarity (top level)
// Word bytes (op 1) are taken one per cycle and ripple down a row of KEY_MAX
// cells, one cell per cycle. Key, end and clear items wait until the row has
// drained; an end result is then registered directly, or comes from the NW-bit
// bit-serial divider when the score needs one (NW is 13 for KEY_MAX 64), and
// every item waits while the divider runs.
// Synchronous reset empties the key, the row and the result register.
// ----------------------------------------------------------------------------
module approx_substring_similarity
   import apxsim_pkg::*;
#(
   parameter int KEY_MAX = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_op,
   input  logic [7:0]        req_ch,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [7:0] rsp_similarity,
   output logic [6:0]        rsp_distance,
   output logic              rsp_key_overflow
);

   // Column values reach KEY_MAX + 1 inside a cell, the key length KEY_MAX.
   localparam int DW = $clog2(KEY_MAX + 2);
   localparam int LW = $clog2(KEY_MAX + 1);
   localparam int IW = $clog2(KEY_MAX);
   localparam int NW = $clog2(KEY_MAX * PCT_SCALE + 1);

   // Key and word state.
   logic [LW-1:0] key_len_ff;
   logic [LW-1:0] key_len_in;
   logic          ovf_ff;
   logic          ovf_in;
   logic          started_ff;
   logic          started_in;
   logic [DW-1:0] best_ff;
   logic [DW-1:0] best_in;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [7:0]        rsp_sim_ff;
   logic [7:0]        rsp_sim_in;
   logic [6:0]        rsp_dist_ff;
   logic [6:0]        rsp_dist_in;
   logic              rsp_ovf_ff;
   logic              rsp_ovf_in;

   // Row of cells.
   cell_ctrl_type     ctrl [KEY_MAX];
   logic [KEY_MAX-1:0] tok_valid;
   logic [7:0]        tok_ch   [KEY_MAX];
   logic [DW-1:0]     tok_old  [KEY_MAX];
   logic [DW-1:0]     tok_new  [KEY_MAX];

   logic           accept;
   logic           take_key;
   logic           take_word;
   logic           take_end;
   logic           take_clear;
   logic           begin_word;
   logic           chain_busy;
   logic [LW-1:0]  len_m1;
   logic [IW-1:0]  tap_idx;
   logic           tap_valid;
   logic [DW-1:0]  tap_val;
   logic [DW+7:0]  best_wide;
   logic [6:0]     dist_sat;
   logic           score_ok;
   logic           need_div;
   logic [LW-1:0]  miss;
   logic [NW-1:0]  num;

   div_status_type div_stat;
   logic [NW-1:0]  div_quo;

   // The row is busy while any cell still carries a word byte.
   assign chain_busy = |tok_valid;

   // Word bytes stream freely; every other item waits for the row to drain.
   // An end item also needs the result register empty.
   assign req_stall = div_stat.busy
                    || (req_op != OP_WORD && chain_busy)
                    || (req_op == OP_END && rsp_valid_ff);

   assign accept     = req_valid && !req_stall;
   assign take_key   = accept && (req_op == OP_KEY);
   assign take_word  = accept && (req_op == OP_WORD);
   assign take_end   = accept && (req_op == OP_END);
   assign take_clear = accept && (req_op == OP_CLEAR);
   assign begin_word = take_word && !started_ff;

   // Each cell sees the word-start clear and its own key write strobe.
   for (genvar i = 0; i < KEY_MAX; i++) begin : g_row
      assign ctrl[i].clear  = begin_word;
      assign ctrl[i].key_we = take_key && (key_len_ff == LW'(i));
      assign ctrl[i].key_ch = req_ch;

      if (i == 0) begin : g_head
         // Row zero of the column is always zero, so the key may start anywhere.
         apxsim_cell #(.DW(DW), .POS(i + 1)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl[i]),
            .in_valid  (take_word),
            .in_ch     (req_ch),
            .in_diag   ('0),
            .in_left   ('0),
            .out_valid (tok_valid[i]),
            .out_ch    (tok_ch[i]),
            .out_old   (tok_old[i]),
            .out_new   (tok_new[i])
         );
      end else begin : g_body
         apxsim_cell #(.DW(DW), .POS(i + 1)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl[i]),
            .in_valid  (tok_valid[i-1]),
            .in_ch     (tok_ch[i-1]),
            .in_diag   (tok_old[i-1]),
            .in_left   (tok_new[i-1]),
            .out_valid (tok_valid[i]),
            .out_ch    (tok_ch[i]),
            .out_old   (tok_old[i]),
            .out_new   (tok_new[i])
         );
      end
   end

   // The cell at the key end reports the full-key distance for each byte.
   assign len_m1    = key_len_ff - LW'(1);
   assign tap_idx   = len_m1[IW-1:0];
   assign tap_valid = (key_len_ff != '0) && tok_valid[tap_idx];
   assign tap_val   = tok_new[tap_idx];

   // Reported distance saturates at the width of the result field.
   assign best_wide = (DW + 8)'(best_ff);
   assign dist_sat  = (best_wide > (DW + 8)'(DIST_MAX)) ? DIST_MAX : best_wide[6:0];

   // A score exists only for a non-empty key against a non-empty word. A
   // single edit scores a fixed 90; every other distance goes through the
   // divider as (length - distance) * 100 / length.
   assign score_ok = (key_len_ff != '0) && started_ff;
   assign need_div = score_ok && (best_ff != DW'(1));
   assign miss     = key_len_ff - best_ff[LW-1:0];
   assign num      = NW'(miss) * NW'(PCT_SCALE);

   apxsim_div #(.NW(NW), .LW(LW)) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (take_end && need_div),
      .num    (num),
      .den    (key_len_ff),
      .status (div_stat),
      .quo    (div_quo)
   );

   // Key, word and best-distance bookkeeping.
   always_comb begin
      key_len_in = key_len_ff;
      ovf_in     = ovf_ff;
      started_in = started_ff;
      best_in    = best_ff;
      if (take_key) begin
         // A key change abandons any word in progress.
         started_in = 1'b0;
         if (key_len_ff < LW'(KEY_MAX)) begin
            key_len_in = key_len_ff + LW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (take_clear) begin
         started_in = 1'b0;
         key_len_in = '0;
         ovf_in     = 1'b0;
      end
      if (take_end) begin
         started_in = 1'b0;
      end
      if (begin_word) begin
         started_in = 1'b1;
         best_in    = DW'(key_len_ff);
      end else if (tap_valid && (tap_val < best_ff)) begin
         best_in = tap_val;
      end
   end

   // Result register: filled by an end transfer or by the divider finishing,
   // emptied by a result transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sim_in   = rsp_sim_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (take_end) begin
         rsp_ovf_in  = ovf_ff;
         rsp_dist_in = score_ok ? dist_sat : '0;
         if (!score_ok) begin
            rsp_valid_in = 1'b1;
            rsp_sim_in   = SIM_EMPTY;
         end else if (!need_div) begin
            rsp_valid_in = 1'b1;
            rsp_sim_in   = SIM_ONE_EDIT;
         end
      end
      if (div_stat.done) begin
         rsp_valid_in = 1'b1;
         // The quotient's last bit lands at this edge, so take the next value.
         rsp_sim_in   = div_quo[7:0];
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      rsp_sim_ff  <= rsp_sim_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      if (reset) begin
         key_len_ff   <= '0;
         ovf_ff       <= 1'b0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_len_ff   <= key_len_in;
         ovf_ff       <= ovf_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_similarity   = rsp_sim_ff;
   assign rsp_distance     = rsp_dist_ff;
   assign rsp_key_overflow = rsp_ovf_ff;

`ifndef SYNTH
   a_word_starts_empty: assert property (@(posedge clock) disable iff (reset)
      begin_word |-> !chain_busy)
      else $error("word started while the cell row still held bytes");

   a_end_after_drain: assert property (@(posedge clock) disable iff (reset)
      take_end |-> (!chain_busy && !div_stat.busy))
      else $error("end transfer taken before the row drained");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      key_len_ff <= LW'(KEY_MAX))
      else $error("key length beyond capacity");

   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> (best_ff <= DW'(key_len_ff)))
      else $error("best distance above key length");
`endif

endmodule
